[rtl/qrm_pkg.sv]
`timescale 1ns / 1ps

package qrm_pkg;

	localparam int FRAC_BITS = 14;

	localparam int IN_W   = 16;
	localparam int OUT_W  = 16;
	localparam int TH_W   = 10;
	localparam int NLANE  = 9;

	// products of two parts, the norm, and the doubled numerators
	localparam int PROD_W = 2 * IN_W;
	localparam int N_W    = PROD_W + 1;
	localparam int NUM_W  = PROD_W + 2;

	// quotient holds up to 1.0, so one bit above the fraction
	localparam int QW     = FRAC_BITS + 1;
	localparam int X_W    = N_W + FRAC_BITS;
	localparam int EXT_W  = (QW + 1 > OUT_W) ? QW + 1 : OUT_W;
	localparam int CMP_W  = (QW > TH_W) ? QW : TH_W;

	localparam int FRONT_STAGES = 5;
	// edges from the accepting edge to the edge that takes the result
	localparam int LAT = FRONT_STAGES + QW + 1;

	localparam logic [TH_W-1:0] SNAP_RESET = TH_W'(2);
	localparam logic [QW-1:0]   LIM_Q      = {1'b1, {FRAC_BITS{1'b0}}};

	typedef struct packed {
		logic            neg;
		logic [N_W-1:0]  rem;
		logic [QW-1:0]   low;
	} div_lane_t;

	typedef struct packed {
		logic                        zero;
		logic [N_W-1:0]              n;
		div_lane_t [NLANE-1:0]       lane;
	} div_item_t;

endpackage

[rtl/qrm_front.sv]
`timescale 1ns / 1ps

module qrm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [qrm_pkg::IN_W-1:0]   q_real,
	input  logic signed [qrm_pkg::IN_W-1:0]   q_i,
	input  logic signed [qrm_pkg::IN_W-1:0]   q_j,
	input  logic signed [qrm_pkg::IN_W-1:0]   q_k,
	output logic                              out_valid,
	output qrm_pkg::div_item_t                out_item
);
	import qrm_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [PROD_W-1:0] rr_s1, ii_s1, jj_s1, kk_s1;
	logic signed [PROD_W-1:0] ij_s1, kr_s1, ik_s1, jr_s1, jk_s1, ir_s1;

	logic signed [N_W-1:0] a_s2, b_s2, c_s2, d_s2;
	logic signed [N_W-1:0] o1_s2, o2_s2, o3_s2, o5_s2, o6_s2, o7_s2;

	logic [N_W-1:0]          n_s3;
	logic signed [NUM_W-1:0] num_s3 [NLANE];

	logic [N_W-1:0] n_s4;
	logic           zero_s4;
	logic           neg_s4 [NLANE];
	logic [N_W-1:0] mag_s4 [NLANE];

	logic [X_W-1:0] x_c [NLANE];
	div_item_t      item_c;
	div_item_t      item_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// the ten pairwise products
	always_ff @(posedge clk) begin
		rr_s1 <= q_real * q_real;
		ii_s1 <= q_i * q_i;
		jj_s1 <= q_j * q_j;
		kk_s1 <= q_k * q_k;
		ij_s1 <= q_i * q_j;
		kr_s1 <= q_k * q_real;
		ik_s1 <= q_i * q_k;
		jr_s1 <= q_j * q_real;
		jk_s1 <= q_j * q_k;
		ir_s1 <= q_i * q_real;
	end

	always_ff @(posedge clk) begin
		a_s2  <= N_W'(rr_s1) + N_W'(ii_s1);
		b_s2  <= N_W'(jj_s1) + N_W'(kk_s1);
		c_s2  <= N_W'(rr_s1) - N_W'(ii_s1);
		d_s2  <= N_W'(jj_s1) - N_W'(kk_s1);
		o1_s2 <= N_W'(ij_s1) - N_W'(kr_s1);
		o2_s2 <= N_W'(ik_s1) + N_W'(jr_s1);
		o3_s2 <= N_W'(ij_s1) + N_W'(kr_s1);
		o5_s2 <= N_W'(jk_s1) - N_W'(ir_s1);
		o6_s2 <= N_W'(ik_s1) - N_W'(jr_s1);
		o7_s2 <= N_W'(jk_s1) + N_W'(ir_s1);
	end

	// diagonal: n - 2(x+y) folds into plus/minus sums of the squares
	always_ff @(posedge clk) begin
		n_s3      <= N_W'(a_s2 + b_s2);
		num_s3[0] <= NUM_W'(a_s2) - NUM_W'(b_s2);
		num_s3[1] <= $signed({o1_s2, 1'b0});
		num_s3[2] <= $signed({o2_s2, 1'b0});
		num_s3[3] <= $signed({o3_s2, 1'b0});
		num_s3[4] <= NUM_W'(c_s2) + NUM_W'(d_s2);
		num_s3[5] <= $signed({o5_s2, 1'b0});
		num_s3[6] <= $signed({o6_s2, 1'b0});
		num_s3[7] <= $signed({o7_s2, 1'b0});
		num_s3[8] <= NUM_W'(c_s2) - NUM_W'(d_s2);
	end

	always_ff @(posedge clk) begin
		n_s4    <= n_s3;
		zero_s4 <= (n_s3 == '0);
		for (int e = 0; e < NLANE; e++) begin
			neg_s4[e] <= num_s3[e][NUM_W-1];
			mag_s4[e] <= N_W'(num_s3[e][NUM_W-1] ? -num_s3[e] : num_s3[e]);
		end
	end

	// dividend with the half-divisor rounding term; top bits seed the remainder
	always_comb begin
		item_c.zero = zero_s4;
		item_c.n    = n_s4;
		for (int e = 0; e < NLANE; e++) begin
			x_c[e] = {mag_s4[e], {FRAC_BITS{1'b0}}} + X_W'(n_s4 >> 1);
			item_c.lane[e].neg = neg_s4[e];
			item_c.lane[e].rem = {1'b0, x_c[e][X_W-1:QW]};
			item_c.lane[e].low = x_c[e][QW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		item_s5 <= item_c;
	end

	assign out_valid = v_s5;
	assign out_item  = item_s5;

endmodule

[rtl/qrm_div_step.sv]
`timescale 1ns / 1ps

module qrm_div_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  qrm_pkg::div_item_t in_item,
	output logic               out_valid,
	output qrm_pkg::div_item_t out_item
);
	import qrm_pkg::*;

	logic [N_W:0]   trial_c [NLANE];
	logic [N_W:0]   diff_c  [NLANE];
	logic           ge_c    [NLANE];
	div_item_t      item_c;
	logic           v_s1;
	div_item_t      item_s1;

	// one restoring step per lane: shift in the next dividend bit, subtract if it fits
	always_comb begin
		item_c = in_item;
		for (int e = 0; e < NLANE; e++) begin
			trial_c[e] = {in_item.lane[e].rem, in_item.lane[e].low[QW-1]};
			diff_c[e]  = trial_c[e] - {1'b0, in_item.n};
			ge_c[e]    = (trial_c[e] >= {1'b0, in_item.n});
			item_c.lane[e].rem = ge_c[e] ? diff_c[e][N_W-1:0] : trial_c[e][N_W-1:0];
			item_c.lane[e].low = {in_item.lane[e].low[QW-2:0], ge_c[e]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item_c;
	end

	assign out_valid = v_s1;
	assign out_item  = item_s1;

endmodule

[rtl/qrm_out.sv]
`timescale 1ns / 1ps

module qrm_out (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  qrm_pkg::div_item_t                      in_item,
	input  logic [qrm_pkg::TH_W-1:0]                snap_threshold,
	output logic                                    done,
	output logic [qrm_pkg::NLANE-1:0][qrm_pkg::OUT_W-1:0] entry,
	output logic                                    zero_norm
);
	import qrm_pkg::*;

	logic [QW-1:0]    sat_c [NLANE];
	logic [QW-1:0]    snap_c [NLANE];
	logic [EXT_W-1:0] val_c [NLANE];
	logic [NLANE-1:0][OUT_W-1:0] entry_c;

	logic                        done_q;
	logic [NLANE-1:0][OUT_W-1:0] entry_q;
	logic                        zero_q;

	always_comb begin
		for (int e = 0; e < NLANE; e++) begin
			sat_c[e]  = (in_item.lane[e].low > LIM_Q) ? LIM_Q : in_item.lane[e].low;
			snap_c[e] = (CMP_W'(sat_c[e]) < CMP_W'(snap_threshold)) ? '0 : sat_c[e];
			val_c[e]  = in_item.lane[e].neg ? -EXT_W'(snap_c[e]) : EXT_W'(snap_c[e]);
			entry_c[e] = in_item.zero ? '0 : val_c[e][OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			zero_q  <= 1'b0;
		end else if (in_valid) begin
			entry_q <= entry_c;
			zero_q  <= in_item.zero;
		end
	end

	assign done      = done_q;
	assign entry     = entry_q;
	assign zero_norm = zero_q;

endmodule

[rtl/quaternion_to_rotation_matrix.sv]
`timescale 1ns / 1ps
// a result passes FRAC_BITS + 7 register stages from start to done; done is the last of them
// throughput: one quaternion per cycle; busy is always low
// cost of a stage: one 16x16 product, one add of 33 to 47 bits, or one quotient bit per lane
// reset clears the valid pipeline and sets snap_threshold to 2; no results are lost
// after reset, and results are never held off by the receiver
module quaternion_to_rotation_matrix (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [qrm_pkg::IN_W-1:0]   q_real,
	input  logic signed [qrm_pkg::IN_W-1:0]   q_i,
	input  logic signed [qrm_pkg::IN_W-1:0]   q_j,
	input  logic signed [qrm_pkg::IN_W-1:0]   q_k,
	input  logic                              cfg_we,
	input  logic [qrm_pkg::TH_W-1:0]          cfg_wdata,
	output logic                              done,
	output logic signed [qrm_pkg::OUT_W-1:0]  entry_0_0,
	output logic signed [qrm_pkg::OUT_W-1:0]  entry_0_1,
	output logic signed [qrm_pkg::OUT_W-1:0]  entry_0_2,
	output logic signed [qrm_pkg::OUT_W-1:0]  entry_1_0,
	output logic signed [qrm_pkg::OUT_W-1:0]  entry_1_1,
	output logic signed [qrm_pkg::OUT_W-1:0]  entry_1_2,
	output logic signed [qrm_pkg::OUT_W-1:0]  entry_2_0,
	output logic signed [qrm_pkg::OUT_W-1:0]  entry_2_1,
	output logic signed [qrm_pkg::OUT_W-1:0]  entry_2_2,
	output logic                              zero_norm
);
	import qrm_pkg::*;

	logic [TH_W-1:0] snap_threshold_q;

	logic      vld_c  [QW+1];
	div_item_t item_c [QW+1];

	logic [NLANE-1:0][OUT_W-1:0] entry_w;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_threshold_q <= SNAP_RESET;
		end else if (cfg_we) begin
			snap_threshold_q <= cfg_wdata;
		end
	end

	qrm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.q_real    (q_real),
		.q_i       (q_i),
		.q_j       (q_j),
		.q_k       (q_k),
		.out_valid (vld_c[0]),
		.out_item  (item_c[0])
	);

	// one quotient bit per stage for all nine entries
	for (genvar g = 0; g < QW; g++) begin : g_div
		qrm_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_c[g]),
			.in_item   (item_c[g]),
			.out_valid (vld_c[g+1]),
			.out_item  (item_c[g+1])
		);
	end

	qrm_out u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (vld_c[QW]),
		.in_item        (item_c[QW]),
		.snap_threshold (snap_threshold_q),
		.done           (done),
		.entry          (entry_w),
		.zero_norm      (zero_norm)
	);

	assign entry_0_0 = $signed(entry_w[0]);
	assign entry_0_1 = $signed(entry_w[1]);
	assign entry_0_2 = $signed(entry_w[2]);
	assign entry_1_0 = $signed(entry_w[3]);
	assign entry_1_1 = $signed(entry_w[4]);
	assign entry_1_2 = $signed(entry_w[5]);
	assign entry_2_0 = $signed(entry_w[6]);
	assign entry_2_1 = $signed(entry_w[7]);
	assign entry_2_2 = $signed(entry_w[8]);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result transaction without a start at the pipeline depth");

	a_zero_entries: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_norm |-> entry_0_0 == '0 && entry_0_1 == '0 && entry_0_2 == '0 &&
			entry_1_0 == '0 && entry_1_1 == '0 && entry_1_2 == '0 &&
			entry_2_0 == '0 && entry_2_1 == '0 && entry_2_2 == '0)
		else $error("zero quaternion gave a nonzero entry");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(entry_0_0) && $stable(entry_2_2) && $stable(zero_norm))
		else $error("result registers changed without a transaction");

endmodule
